### rtl/stdq_pkg.sv
// Package for the sorted task deadline queue.
// Holds the request and status codes and the fixed field widths.
// No dependencies.
package stdq_pkg;

  localparam int REQ_W   = 2;
  localparam int TASK_W  = 4;
  localparam int DELAY_W = 16;
  localparam int NOW_W   = 32;
  localparam int SLACK_W = 16;
  localparam int STAT_W  = 2;
  localparam int DL_W    = 32;

  // A tick pops at most this many entries; the rest wait for the next tick.
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // The last code is not a request; it only answers with one plain result.
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_WAITING     = 2'd1,
    ST_NOT_WAITING = 2'd2
  } status_e;

endpackage

### rtl/stdq_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Read data comes from a register. No dependencies.
module stdq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 42
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/sorted_task_deadline_queue.sv
// Sorted task deadline queue: doubly linked list of task IDs in one RAM.
// Depends on stdq_pkg and stdq_ram.
//
//   Channel  | Direction | Handshake              | Payload
//   ---------+-----------+------------------------+-----------------------------------------
//   request  | in        | in_valid_i/in_stall_o  | req_type, task_id, delay, now_time
//   result   | out       | out_valid_o/out_stall_i| status, expired_*, last, queue_empty,
//            |           |                        | next_deadline
//   config   | in        | cfg_we_i               | cfg_wdata_i (expiry_slack)
//
// One request is worked on at a time. A cancel reads the task and patches its neighbours,
// an insert walks the list from the head past every entry that expires no later, and a
// tick pops due entries from the head up to the result cap, one result per popped entry,
// or one plain result when nothing is due. The single RAM read port is registered, so
// every list hop is a read and a wait.
// Reset clears the head pointer, the waiting bits and the control state; the RAM
// needs no clearing since an entry is only read while it is linked.
// A stalled result holds the machine before the next result, and a new request
// may be transferred while the last result of the previous one is still waiting.
module sorted_task_deadline_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [stdq_pkg::SLACK_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [stdq_pkg::REQ_W-1:0]    req_type_i,
  input  logic [stdq_pkg::TASK_W-1:0]   task_id_i,
  input  logic [stdq_pkg::DELAY_W-1:0]  delay_i,
  input  logic [stdq_pkg::NOW_W-1:0]    now_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [stdq_pkg::STAT_W-1:0]   status_o,
  output logic                          expired_valid_o,
  output logic [stdq_pkg::TASK_W-1:0]   expired_task_o,
  output logic                          last_o,
  output logic                          queue_empty_o,
  output logic [stdq_pkg::DL_W-1:0]     next_deadline_o
);
  import stdq_pkg::*;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int LINK_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(QUEUE_DEPTH);

  // One RAM word per task: forward link, backward link and expiry time.
  typedef struct packed {
    logic [LINK_W-1:0]     nxt;
    logic [LINK_W-1:0]     prv;
    logic [TIME_WIDTH-1:0] exp;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_HD,
    S_INS_WALK,
    S_INS_NRD,
    S_LNK_CUR,
    S_LNK_T,
    S_LNK_NXT,
    S_TICK,
    S_UN_T,
    S_UN_P,
    S_UN_NX,
    S_UN_N,
    S_EMIT
  } state_e;

  function automatic logic lk_ok(input logic [LINK_W-1:0] l);
    return l < LINK_NONE;
  endfunction

  state_e                  state_q;
  logic [REQ_W-1:0]        req_q;
  logic [SLACK_W-1:0]      slack_q;
  logic [QUEUE_DEPTH-1:0]  waiting_q;
  logic [LINK_W-1:0]       head_q;
  logic [TIME_WIDTH-1:0]   head_exp_q;
  logic [IDX_W-1:0]        t_q;        // task being inserted or unlinked
  logic [TIME_WIDTH-1:0]   exp_q;
  logic [TIME_WIDTH-1:0]   limit_q;
  logic                    front_q;
  logic [LINK_W-1:0]       cur_q;
  logic [LINK_W-1:0]       nxt_q;
  ent_t                    cur_ent_q;
  ent_t                    nxt_ent_q;
  logic [LINK_W-1:0]       p_q;
  logic [LINK_W-1:0]       n_q;
  logic [CNT_W-1:0]        cnt_q;
  status_e                 stat_q;
  logic                    expv_q;

  logic                    out_valid_q;
  logic [STAT_W-1:0]       out_status_q;
  logic                    out_expv_q;
  logic [TASK_W-1:0]       out_task_q;
  logic                    out_last_q;
  logic                    out_empty_q;
  logic [DL_W-1:0]         out_dl_q;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  ent_t                    ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [$bits(ent_t)-1:0] ram_rdata;
  ent_t                    rd;

  logic                    in_acc;
  logic                    tid_ok;
  logic [IDX_W-1:0]        tid_idx;
  logic [TIME_WIDTH-1:0]   now_t;
  logic [TIME_WIDTH-1:0]   ins_exp;
  logic [TIME_WIDTH-1:0]   tick_limit;
  logic                    more_due;
  logic                    emit_last;
  logic                    out_free;

  assign rd         = ent_t'(ram_rdata);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tid_ok     = (32'(task_id_i) < QUEUE_DEPTH);
  assign tid_idx    = IDX_W'(task_id_i);
  assign now_t      = TIME_WIDTH'(now_time_i);
  assign ins_exp    = now_t + TIME_WIDTH'(delay_i);
  assign tick_limit = now_t + TIME_WIDTH'(slack_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Another pop follows when the cap is not reached and the new head is due.
  assign more_due  = (cnt_q < CNT_W'(MAX_RESULTS)) && lk_ok(head_q) && (head_exp_q <= limit_q);
  assign emit_last = !((req_q == REQ_TICK) && expv_q && more_due);

  stdq_ram #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH($bits(ent_t))
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // RAM port control: reads look up the next hop; writes patch one link of a neighbour or write the new entry whole.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = t_q;
    ram_wdata = '0;
    ram_raddr = IDX_W'(head_q);
    case (state_q)
      S_IDLE: begin
        if (req_type_i == REQ_CANCEL) begin
          ram_raddr = tid_idx;
        end
      end
      S_INS_WALK: ram_raddr = IDX_W'(cur_ent_q.nxt);
      S_UN_T:     ram_raddr = IDX_W'(rd.prv);
      S_UN_NX:    ram_raddr = IDX_W'(n_q);
      S_LNK_CUR: begin
        ram_we        = lk_ok(cur_q);
        ram_waddr     = IDX_W'(cur_q);
        ram_wdata     = cur_ent_q;
        ram_wdata.nxt = LINK_W'(t_q);
      end
      S_LNK_T: begin
        ram_we        = 1'b1;
        ram_wdata.nxt = nxt_q;
        ram_wdata.prv = cur_q;
        ram_wdata.exp = exp_q;
      end
      S_LNK_NXT: begin
        ram_we        = lk_ok(nxt_q);
        ram_waddr     = IDX_W'(nxt_q);
        ram_wdata     = nxt_ent_q;
        ram_wdata.prv = LINK_W'(t_q);
      end
      S_UN_P: begin
        ram_we        = 1'b1;
        ram_waddr     = IDX_W'(p_q);
        ram_wdata     = rd;
        ram_wdata.nxt = n_q;
      end
      S_UN_N: begin
        ram_we        = 1'b1;
        ram_waddr     = IDX_W'(n_q);
        ram_wdata     = rd;
        ram_wdata.prv = p_q;
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slack_q     <= '0;
      waiting_q   <= '0;
      head_q      <= LINK_NONE;
      head_exp_q  <= '1;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        slack_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            req_q   <= req_type_i;
            t_q     <= tid_idx;
            exp_q   <= ins_exp;
            limit_q <= tick_limit;
            cnt_q   <= '0;
            expv_q  <= 1'b0;
            stat_q  <= ST_OK;
            case (req_type_i)
              REQ_INSERT: begin
                if (!tid_ok) begin
                  stat_q  <= ST_NOT_WAITING;
                  state_q <= S_EMIT;
                end else if (waiting_q[tid_idx]) begin
                  stat_q  <= ST_WAITING;
                  state_q <= S_EMIT;
                end else if (!lk_ok(head_q)) begin
                  cur_q   <= LINK_NONE;
                  nxt_q   <= LINK_NONE;
                  state_q <= S_LNK_CUR;
                end else begin
                  front_q <= (head_exp_q > ins_exp);
                  state_q <= S_INS_HD;
                end
              end
              REQ_CANCEL: begin
                if (!lk_ok(head_q) || !tid_ok || !waiting_q[tid_idx]) begin
                  stat_q  <= ST_NOT_WAITING;
                  state_q <= S_EMIT;
                end else begin
                  state_q <= S_UN_T;
                end
              end
              REQ_TICK: state_q <= S_TICK;
              default:  state_q <= S_EMIT;
            endcase
          end
        end

        S_INS_HD: begin
          if (front_q) begin
            cur_q     <= LINK_NONE;
            nxt_q     <= head_q;
            nxt_ent_q <= rd;
            state_q   <= S_LNK_CUR;
          end else begin
            cur_q     <= head_q;
            cur_ent_q <= rd;
            state_q   <= S_INS_WALK;
          end
        end

        S_INS_WALK: begin
          nxt_q <= cur_ent_q.nxt;
          if (lk_ok(cur_ent_q.nxt)) begin
            state_q <= S_INS_NRD;
          end else begin
            state_q <= S_LNK_CUR;
          end
        end

        S_INS_NRD: begin
          // Stop before the first entry that expires strictly later.
          if (rd.exp > exp_q) begin
            nxt_ent_q <= rd;
            state_q   <= S_LNK_CUR;
          end else begin
            cur_q     <= nxt_q;
            cur_ent_q <= rd;
            state_q   <= S_INS_WALK;
          end
        end

        S_LNK_CUR: state_q <= S_LNK_T;

        S_LNK_T: begin
          waiting_q[t_q] <= 1'b1;
          if (!lk_ok(cur_q)) begin
            head_q     <= LINK_W'(t_q);
            head_exp_q <= exp_q;
          end
          state_q <= S_LNK_NXT;
        end

        S_LNK_NXT: state_q <= S_EMIT;

        S_TICK: begin
          if (more_due) begin
            t_q     <= IDX_W'(head_q);
            cnt_q   <= cnt_q + 1'b1;
            expv_q  <= 1'b1;
            state_q <= S_UN_T;
          end else begin
            expv_q  <= 1'b0;
            state_q <= S_EMIT;
          end
        end

        S_UN_T: begin
          p_q            <= rd.prv;
          n_q            <= rd.nxt;
          waiting_q[t_q] <= 1'b0;
          state_q        <= lk_ok(rd.prv) ? S_UN_P : S_UN_NX;
        end

        S_UN_P: state_q <= S_UN_NX;

        S_UN_NX: begin
          if (lk_ok(n_q)) begin
            state_q <= S_UN_N;
          end else begin
            if (!lk_ok(p_q)) begin
              head_q     <= LINK_NONE;
              head_exp_q <= '1;
            end
            state_q <= S_EMIT;
          end
        end

        S_UN_N: begin
          if (!lk_ok(p_q)) begin
            head_q     <= n_q;
            head_exp_q <= rd.exp;
          end
          state_q <= S_EMIT;
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= stat_q;
            out_expv_q   <= expv_q;
            out_task_q   <= expv_q ? TASK_W'(t_q) : '0;
            out_last_q   <= emit_last;
            out_empty_q  <= !lk_ok(head_q);
            out_dl_q     <= lk_ok(head_q) ? DL_W'(head_exp_q) : '1;
            state_q      <= emit_last ? S_IDLE : S_TICK;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign expired_valid_o = out_expv_q;
  assign expired_task_o  = out_task_q;
  assign last_o          = out_last_q;
  assign queue_empty_o   = out_empty_q;
  assign next_deadline_o = out_dl_q;

  // An empty list leaves no task marked as waiting.
  a_empty_none_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !lk_ok(head_q)) |-> (waiting_q == '0))
    else $error("queue empty but a task is still marked waiting");

  // In the idle state the head of a nonempty list is a waiting task.
  a_head_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && lk_ok(head_q)) |-> waiting_q[IDX_W'(head_q)])
    else $error("list head is not a waiting task");

  // A tick never pops more than the result cap.
  a_pop_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("pop count exceeded the cap");

  // A transferred request keeps the input stalled in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("request taken while the previous one is still in work");

endmodule
